@@ rtl/keypad_code_lock_controller_assert.svh @@
// ----------------------------------------------------------------------------
// keypad code lock controller assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define KCLC_CHECK_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad lock check failed");

// next-cycle implication
`define KCLC_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad lock check failed");

`endif

@@ rtl/kclc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kclc_pkg
// shared codes, reset values and the result word type of the code lock
// ----------------------------------------------------------------------------
package kclc_pkg;

    localparam int DEF_CODE_DIGITS = 5;
    localparam int ADDR_W          = 3;

    localparam logic [2:0] ATTEMPT_LIMIT_RST = 3'd3;
    localparam logic [4:0] LOCK_TIMEOUT_RST  = 5'd10;

    // register word index (paddr[2])
    localparam logic REG_ATTEMPT_LIMIT = 1'b0;

    localparam logic [1:0] CMD_KEY  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_POT  = 2'd2;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_A         = 4'd10;
    localparam logic [3:0] KEY_B         = 4'd11;
    localparam logic [3:0] KEY_C         = 4'd12;
    localparam logic [3:0] KEY_D         = 4'd13;
    localparam logic [3:0] KEY_HASH      = 4'd15;

    localparam logic [3:0] EV_NONE         = 4'd0;
    localparam logic [3:0] EV_DIGIT        = 4'd1;
    localparam logic [3:0] EV_CANCEL       = 4'd2;
    localparam logic [3:0] EV_SAVED        = 4'd3;
    localparam logic [3:0] EV_MISMATCH     = 4'd4;
    localparam logic [3:0] EV_WRONG        = 4'd5;
    localparam logic [3:0] EV_EXCEEDED     = 4'd6;
    localparam logic [3:0] EV_UNLOCKED     = 4'd7;
    localparam logic [3:0] EV_LOCKED       = 4'd8;
    localparam logic [3:0] EV_TIMEOUT_SAVE = 4'd9;
    localparam logic [3:0] EV_ERASE_PROMPT = 4'd10;
    localparam logic [3:0] EV_ERASED       = 4'd11;
    localparam logic [3:0] EV_ERASE_CANCEL = 4'd12;

    localparam logic [3:0] MODE_SETUP      = 4'd0;
    localparam logic [3:0] MODE_SETUP_CONF = 4'd1;
    localparam logic [3:0] MODE_MENU       = 4'd2;
    localparam logic [3:0] MODE_OPEN       = 4'd3;
    localparam logic [3:0] MODE_OLD        = 4'd4;
    localparam logic [3:0] MODE_NEW        = 4'd5;
    localparam logic [3:0] MODE_NEW_CONF   = 4'd6;
    localparam logic [3:0] MODE_ADJUST     = 4'd7;
    localparam logic [3:0] MODE_TIME_CODE  = 4'd8;
    localparam logic [3:0] MODE_UNLOCKED   = 4'd9;
    localparam logic [3:0] MODE_ERASE      = 4'd10;

    typedef struct packed {
        logic [3:0] event_res;
        logic [3:0] mode_now;
        logic       door_open;
        logic       alarm_pulse;
        logic [4:0] shown_timeout;
        logic [4:0] seconds_left;
        logic [2:0] digits_entered;
    } result_t;

endpackage

@@ rtl/kclc_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kclc_fsm
// lock state and the one-pass next-state decode for one input word
// ----------------------------------------------------------------------------
module kclc_fsm #(
    parameter int CODE_DIGITS = kclc_pkg::DEF_CODE_DIGITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [1:0]        command,
    input  logic [3:0]        key_code,
    input  logic [11:0]       pot_sample,
    input  logic [2:0]        attempt_limit,
    output kclc_pkg::result_t res
);

    localparam int CW = $clog2(CODE_DIGITS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CODE_DIGITS);

    typedef enum logic [3:0] {
        M_SETUP      = kclc_pkg::MODE_SETUP,
        M_SETUP_CONF = kclc_pkg::MODE_SETUP_CONF,
        M_MENU       = kclc_pkg::MODE_MENU,
        M_OPEN       = kclc_pkg::MODE_OPEN,
        M_OLD        = kclc_pkg::MODE_OLD,
        M_NEW        = kclc_pkg::MODE_NEW,
        M_NEW_CONF   = kclc_pkg::MODE_NEW_CONF,
        M_ADJUST     = kclc_pkg::MODE_ADJUST,
        M_TIME_CODE  = kclc_pkg::MODE_TIME_CODE,
        M_UNLOCKED   = kclc_pkg::MODE_UNLOCKED,
        M_ERASE      = kclc_pkg::MODE_ERASE
    } mode_t;

    typedef logic [CODE_DIGITS-1:0][3:0] code_t;

    mode_t         mode_reg, mode_next;
    code_t         saved_reg, saved_next;
    logic          valid_reg, valid_next;
    code_t         entry_reg, entry_next;
    code_t         confirm_reg, confirm_next;
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    fails_reg, fails_next;
    logic [4:0]    timeout_reg, timeout_next;
    logic [4:0]    pending_reg, pending_next;
    logic [4:0]    cd_reg, cd_next;

    code_t         ent_w, conf_w;
    logic [CW-1:0] cnt_w;
    logic          use_conf, full, match_pair, match_saved;
    logic [2:0]    fails_inc;
    logic [4:0]    cd_dec;
    logic [3:0]    ev;
    logic          alarm;
    logic [4:0]    pot_secs;

    logic [16:0]   pot_x;
    logic [4:0]    pot_q0;
    logic [12:0]   pot_r;

    // 5 + pot*25/4095: floor by 4096 is off by at most one, fixed by one compare
    always_comb
    begin
        pot_x    = 17'(pot_sample) * 17'd25;
        pot_q0   = pot_x[16:12];
        pot_r    = 13'(pot_x[11:0]) + 13'(pot_q0);
        pot_secs = 5'd5 + pot_q0 + ((pot_r >= 13'd4095) ? 5'd1 : 5'd0);
    end

    // digit write into the active buffer
    always_comb
    begin
        use_conf = (mode_reg == M_SETUP_CONF) || (mode_reg == M_NEW_CONF);
        ent_w    = entry_reg;
        conf_w   = confirm_reg;
        cnt_w    = count_reg;
        if (count_reg < FULL_CNT)
        begin
            for (int i = 0; i < CODE_DIGITS; i++)
            begin
                if (count_reg == CW'(i))
                begin
                    if (use_conf)
                    begin
                        conf_w[i] = key_code;
                    end
                    else
                    begin
                        ent_w[i] = key_code;
                    end
                end
            end
            cnt_w = CW'(count_reg + 1'b1);
        end
        full        = (cnt_w >= FULL_CNT);
        match_pair  = (ent_w == conf_w);
        match_saved = valid_reg && (ent_w == saved_reg);
        fails_inc   = fails_reg + 3'd1;
        cd_dec      = (cd_reg != 5'd0) ? (cd_reg - 5'd1) : cd_reg;
    end

    always_comb
    begin
        mode_next    = mode_reg;
        saved_next   = saved_reg;
        valid_next   = valid_reg;
        entry_next   = entry_reg;
        confirm_next = confirm_reg;
        count_next   = count_reg;
        fails_next   = fails_reg;
        timeout_next = timeout_reg;
        pending_next = pending_reg;
        cd_next      = cd_reg;
        ev           = kclc_pkg::EV_NONE;
        alarm        = 1'b0;

        unique case (command)
            kclc_pkg::CMD_KEY:
            begin
                unique case (mode_reg)
                    M_MENU:
                    begin
                        if (key_code == kclc_pkg::KEY_A)
                        begin
                            entry_next   = '0;
                            confirm_next = '0;
                            count_next   = '0;
                            mode_next    = M_OPEN;
                        end
                        else if (key_code == kclc_pkg::KEY_B)
                        begin
                            entry_next   = '0;
                            confirm_next = '0;
                            count_next   = '0;
                            mode_next    = M_OLD;
                        end
                        else if (key_code == kclc_pkg::KEY_C)
                        begin
                            pending_next = timeout_reg;
                            mode_next    = M_ADJUST;
                        end
                        else if (key_code == kclc_pkg::KEY_D)
                        begin
                            mode_next = M_ERASE;
                            ev        = kclc_pkg::EV_ERASE_PROMPT;
                        end
                    end
                    M_ADJUST:
                    begin
                        if (key_code == kclc_pkg::KEY_D)
                        begin
                            entry_next   = '0;
                            confirm_next = '0;
                            count_next   = '0;
                            mode_next    = M_TIME_CODE;
                        end
                        else if (key_code == kclc_pkg::KEY_HASH)
                        begin
                            mode_next = M_MENU;
                            ev        = kclc_pkg::EV_CANCEL;
                        end
                    end
                    M_ERASE:
                    begin
                        if (key_code == kclc_pkg::KEY_HASH)
                        begin
                            mode_next    = M_SETUP;
                            saved_next   = '0;
                            valid_next   = 1'b0;
                            entry_next   = '0;
                            confirm_next = '0;
                            count_next   = '0;
                            fails_next   = '0;
                            timeout_next = kclc_pkg::LOCK_TIMEOUT_RST;
                            pending_next = kclc_pkg::LOCK_TIMEOUT_RST;
                            cd_next      = '0;
                            ev           = kclc_pkg::EV_ERASED;
                        end
                        else
                        begin
                            mode_next = M_MENU;
                            ev        = kclc_pkg::EV_ERASE_CANCEL;
                        end
                    end
                    M_UNLOCKED:
                    begin
                        ev = kclc_pkg::EV_NONE;
                    end
                    M_SETUP, M_SETUP_CONF, M_OPEN, M_OLD, M_NEW, M_NEW_CONF, M_TIME_CODE:
                    begin
                        if (key_code <= kclc_pkg::KEY_DIGIT_MAX)
                        begin
                            entry_next   = ent_w;
                            confirm_next = conf_w;
                            count_next   = cnt_w;
                            ev           = kclc_pkg::EV_DIGIT;
                            if (full)
                            begin
                                unique case (mode_reg)
                                    M_SETUP:
                                    begin
                                        count_next = '0;
                                        mode_next  = M_SETUP_CONF;
                                    end
                                    M_NEW:
                                    begin
                                        count_next = '0;
                                        mode_next  = M_NEW_CONF;
                                    end
                                    M_SETUP_CONF, M_NEW_CONF:
                                    begin
                                        entry_next   = '0;
                                        confirm_next = '0;
                                        count_next   = '0;
                                        if (match_pair)
                                        begin
                                            saved_next = ent_w;
                                            valid_next = valid_reg || (mode_reg == M_SETUP_CONF);
                                            mode_next  = M_MENU;
                                            ev         = kclc_pkg::EV_SAVED;
                                        end
                                        else
                                        begin
                                            mode_next = (mode_reg == M_SETUP_CONF) ? M_SETUP
                                                                                   : M_NEW;
                                            ev        = kclc_pkg::EV_MISMATCH;
                                        end
                                    end
                                    M_OPEN:
                                    begin
                                        entry_next   = '0;
                                        confirm_next = '0;
                                        count_next   = '0;
                                        if (match_saved)
                                        begin
                                            mode_next  = M_UNLOCKED;
                                            cd_next    = timeout_reg;
                                            fails_next = '0;
                                            ev         = kclc_pkg::EV_UNLOCKED;
                                        end
                                        else
                                        begin
                                            mode_next = M_MENU;
                                            if (fails_inc >= attempt_limit)
                                            begin
                                                fails_next = '0;
                                                alarm      = 1'b1;
                                                ev         = kclc_pkg::EV_EXCEEDED;
                                            end
                                            else
                                            begin
                                                fails_next = fails_inc;
                                                ev         = kclc_pkg::EV_WRONG;
                                            end
                                        end
                                    end
                                    M_OLD:
                                    begin
                                        entry_next   = '0;
                                        confirm_next = '0;
                                        count_next   = '0;
                                        mode_next    = match_saved ? M_NEW : M_MENU;
                                        ev           = match_saved ? kclc_pkg::EV_DIGIT
                                                                   : kclc_pkg::EV_WRONG;
                                    end
                                    default:
                                    begin
                                        // timeout code entry
                                        entry_next   = '0;
                                        confirm_next = '0;
                                        count_next   = '0;
                                        mode_next    = M_MENU;
                                        if (match_saved)
                                        begin
                                            timeout_next = pending_reg;
                                            ev           = kclc_pkg::EV_TIMEOUT_SAVE;
                                        end
                                        else
                                        begin
                                            ev = kclc_pkg::EV_WRONG;
                                        end
                                    end
                                endcase
                            end
                        end
                        else if (key_code == kclc_pkg::KEY_HASH)
                        begin
                            entry_next   = '0;
                            confirm_next = '0;
                            count_next   = '0;
                            mode_next    = ((mode_reg == M_SETUP) || (mode_reg == M_SETUP_CONF))
                                           ? M_SETUP : M_MENU;
                            ev           = kclc_pkg::EV_CANCEL;
                        end
                    end
                    default:
                    begin
                        ev = kclc_pkg::EV_NONE;
                    end
                endcase
            end
            kclc_pkg::CMD_TICK:
            begin
                if (mode_reg == M_UNLOCKED)
                begin
                    cd_next = cd_dec;
                    if (cd_dec == 5'd0)
                    begin
                        mode_next = M_MENU;
                        ev        = kclc_pkg::EV_LOCKED;
                    end
                end
            end
            kclc_pkg::CMD_POT:
            begin
                if (mode_reg == M_ADJUST)
                begin
                    pending_next = pot_secs;
                end
            end
            default:
            begin
                ev = kclc_pkg::EV_NONE;
            end
        endcase

        res.event_res      = ev;
        res.mode_now       = mode_next;
        res.door_open      = (mode_next == M_UNLOCKED);
        res.alarm_pulse    = alarm;
        res.shown_timeout  = pending_next;
        res.seconds_left   = cd_next;
        res.digits_entered = 3'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_SETUP;
            saved_reg   <= '0;
            valid_reg   <= 1'b0;
            entry_reg   <= '0;
            confirm_reg <= '0;
            count_reg   <= '0;
            fails_reg   <= '0;
            timeout_reg <= kclc_pkg::LOCK_TIMEOUT_RST;
            pending_reg <= kclc_pkg::LOCK_TIMEOUT_RST;
            cd_reg      <= '0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            saved_reg   <= saved_next;
            valid_reg   <= valid_next;
            entry_reg   <= entry_next;
            confirm_reg <= confirm_next;
            count_reg   <= count_next;
            fails_reg   <= fails_next;
            timeout_reg <= timeout_next;
            pending_reg <= pending_next;
            cd_reg      <= cd_next;
        end
    end

endmodule

@@ rtl/keypad_code_lock_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_controller
// keypad code lock: setup, open, change code, auto-lock timeout and erase
// ----------------------------------------------------------------------------
// Takes one word (key press, one-second tick or potentiometer sample) per
// clock while the result is not stalled and gives exactly one result word for
// each. A word is captured in an input register; then the lock decode runs in
// one pass and the result lands in the output register while the lock state
// updates, so the rate is one word per cycle when res_stall is low. A stalled
// result holds the output register and backs up into the input register,
// which still takes one more word. attempt_limit is written over the APB port
// at byte address 0 and should be changed only while no word is in flight.
module keypad_code_lock_controller #(
    parameter int CODE_DIGITS = kclc_pkg::DEF_CODE_DIGITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kclc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [1:0]                  command,
    input  logic [3:0]                  key_code,
    input  logic [11:0]                 pot_sample,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [3:0]                  event_res,
    output logic [3:0]                  mode_now,
    output logic                        door_open,
    output logic                        alarm_pulse,
    output logic [4:0]                  shown_timeout,
    output logic [4:0]                  seconds_left,
    output logic [2:0]                  digits_entered
);

    logic [2:0]        limit_reg;
    logic              in_vld_reg;
    logic [1:0]        cmd_reg;
    logic [3:0]        key_reg;
    logic [11:0]       pot_reg;
    logic              out_vld_reg;
    kclc_pkg::result_t res_reg;
    kclc_pkg::result_t res_next;
    logic              advance;
    logic              take;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == kclc_pkg::REG_ATTEMPT_LIMIT) ? {29'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= kclc_pkg::ATTEMPT_LIMIT_RST;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == kclc_pkg::REG_ATTEMPT_LIMIT))
        begin
            limit_reg <= pwdata[2:0];
        end
    end

    // decode runs when the output register is free or being emptied
    assign advance    = in_vld_reg && (!out_vld_reg || !res_stall);
    assign item_stall = in_vld_reg && !advance;
    assign take       = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= command;
            key_reg <= key_code;
            pot_reg <= pot_sample;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    kclc_fsm #(
        .CODE_DIGITS(CODE_DIGITS)
    ) u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .command      (cmd_reg),
        .key_code     (key_reg),
        .pot_sample   (pot_reg),
        .attempt_limit(limit_reg),
        .res          (res_next)
    );

    assign res_valid      = out_vld_reg;
    assign event_res      = res_reg.event_res;
    assign mode_now       = res_reg.mode_now;
    assign door_open      = res_reg.door_open;
    assign alarm_pulse    = res_reg.alarm_pulse;
    assign shown_timeout  = res_reg.shown_timeout;
    assign seconds_left   = res_reg.seconds_left;
    assign digits_entered = res_reg.digits_entered;

endmodule

@@ rtl/kclc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kclc_checker
// port-level checks on the result channel of the code lock
// ----------------------------------------------------------------------------
`include "keypad_code_lock_controller_assert.svh"

module kclc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_stall,
    input logic [3:0] event_res,
    input logic [3:0] mode_now,
    input logic       door_open,
    input logic       alarm_pulse,
    input logic [4:0] shown_timeout,
    input logic [4:0] seconds_left
);

    `KCLC_CHECK_NOW(door_matches_mode, res_valid, door_open == (mode_now == kclc_pkg::MODE_UNLOCKED))

    `KCLC_CHECK_NOW(locked_no_countdown, res_valid && !door_open, seconds_left == 5'd0)

    `KCLC_CHECK_NOW(alarm_has_event, res_valid && alarm_pulse, event_res == kclc_pkg::EV_EXCEEDED)

    `KCLC_CHECK_NOW(timeout_in_range, res_valid, (shown_timeout >= 5'd5) && (shown_timeout <= 5'd30))

    `KCLC_CHECK_NEXT(stalled_word_holds, res_valid && res_stall, res_valid && $stable(event_res))

endmodule

bind keypad_code_lock_controller kclc_checker u_kclc_checker (.*);
